// ----- sv/software_timer_bank_top_macros.svh -----
// assertion macros used by the checker file
`ifndef SOFTWARE_TIMER_BANK_TOP_MACROS_SVH
`define SOFTWARE_TIMER_BANK_TOP_MACROS_SVH

// implication in the same cycle, sampled on clk, quiet while in reset
`define STB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle
`define STB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/stb_pkg.sv -----
// ----------------------------------------------------------------------------
// stb_pkg
// Shared constants and request codes for the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int TIMER_COUNT_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;

  localparam int REQ_W   = 4;
  localparam int INDEX_W = 8;
  localparam int TIME_W  = 32;

  localparam logic [REQ_W-1:0] REQ_TICK          = 4'd0;
  localparam logic [REQ_W-1:0] REQ_SET           = 4'd1;
  localparam logic [REQ_W-1:0] REQ_START         = 4'd2;
  localparam logic [REQ_W-1:0] REQ_STOP          = 4'd3;
  localparam logic [REQ_W-1:0] REQ_INIT          = 4'd4;
  localparam logic [REQ_W-1:0] REQ_ASK_ACTIVE    = 4'd5;
  localparam logic [REQ_W-1:0] REQ_ASK_EXPIRED   = 4'd6;
  localparam logic [REQ_W-1:0] REQ_CLEAR_EXPIRED = 4'd7;
  localparam logic [REQ_W-1:0] REQ_READ_TIME     = 4'd8;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_TIMER = 1'b1;

endpackage

// ----- sv/stb_req_if.sv -----
// ----------------------------------------------------------------------------
// stb_req_if
// Request channel of the timer bank: valid/ready with the request payload.
// ----------------------------------------------------------------------------
interface stb_req_if import stb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [INDEX_W-1:0] timer_index;
  logic [TIME_W-1:0]  new_time;

  modport source (output valid, output req_type, output timer_index, output new_time,
                  input ready);
  modport sink   (input valid, input req_type, input timer_index, input new_time,
                  output ready);
endinterface

// ----- sv/stb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// stb_rsp_if
// Response channel of the timer bank: valid/ready with the response payload.
// ----------------------------------------------------------------------------
interface stb_rsp_if import stb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic              answer_flag;
  logic [TIME_W-1:0] time_value;

  modport source (output valid, output status, output answer_flag, output time_value,
                  input ready);
  modport sink   (input valid, input status, input answer_flag, input time_value,
                  output ready);
endinterface

// ----- sv/software_timer_bank_top.sv -----
// ----------------------------------------------------------------------------
// software_timer_bank_top
// Bank of one-shot countdown timers with a free-running tick counter.
// Requests come in on in_req (valid/ready), one response per request leaves
// on out_rsp (valid/ready) from an output register.
// A tick bumps the free-running time and then sweeps every timer through one
// shared decrementer, one timer per cycle. All other requests complete on accept;
// the response of any request is shown the cycle after accept.
// The sweep is what limits throughput: in_req.ready stays low until the last
// timer has been visited.
// A request is also held off while the previous response waits in the
// output register and out_rsp.ready is low; a stalled response holds steady.
// Synchronous active-low reset clears all counts, active and expired bits,
// the free-running time and the output valid bit; the response payload is not reset.
// ----------------------------------------------------------------------------
module software_timer_bank_top import stb_pkg::*; #(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input logic  clk,
  input logic  rst_n,
  stb_req_if.sink   in_req,
  stb_rsp_if.source out_rsp
);

  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic                  state_r;
  logic [IDX_W-1:0]      ptr_r;
  logic [COUNT_BITS-1:0] count_r [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] active_r;
  logic [TIMER_COUNT-1:0] expired_r;
  logic [TIME_W-1:0]     free_time_r;

  logic                  out_valid_r;
  logic                  status_r;
  logic                  flag_r;
  logic [TIME_W-1:0]     time_r;

  logic                  accept;
  logic                  idx_ok;
  logic [IDX_W-1:0]      sel;
  logic [COUNT_BITS-1:0] load_val;
  logic [COUNT_BITS-1:0] dec_val;
  logic                  ptr_last;
  logic                  status_nxt;
  logic                  flag_nxt;
  logic [TIME_W-1:0]     time_nxt;

  assign in_req.ready = (state_r == ST_IDLE) && (!out_valid_r || out_rsp.ready);
  assign accept       = in_req.valid && in_req.ready;
  assign idx_ok       = in_req.timer_index < INDEX_W'(TIMER_COUNT);
  assign sel          = in_req.timer_index[IDX_W-1:0];
  assign load_val     = COUNT_BITS'(in_req.new_time);
  // shared decrementer, used once per timer during a sweep
  assign dec_val      = count_r[ptr_r] - COUNT_BITS'(1);
  assign ptr_last     = ptr_r == IDX_W'(TIMER_COUNT - 1);

  always_comb begin
    status_nxt = STATUS_OK;
    flag_nxt   = 1'b0;
    time_nxt   = '0;
    case (in_req.req_type) inside
      REQ_TICK: begin
      end
      REQ_READ_TIME: begin
        time_nxt = free_time_r;
      end
      REQ_SET, REQ_START, REQ_STOP, REQ_INIT, REQ_CLEAR_EXPIRED: begin
        if (!idx_ok) status_nxt = STATUS_NO_TIMER;
      end
      REQ_ASK_ACTIVE: begin
        if (!idx_ok) status_nxt = STATUS_NO_TIMER;
        else flag_nxt = active_r[sel];
      end
      REQ_ASK_EXPIRED: begin
        if (!idx_ok) status_nxt = STATUS_NO_TIMER;
        else flag_nxt = expired_r[sel];
      end
      default: begin
        status_nxt = STATUS_NO_TIMER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      active_r    <= '0;
      expired_r   <= '0;
      free_time_r <= '0;
      for (int i = 0; i < TIMER_COUNT; i++) count_r[i] <= '0;
    end else if (accept) begin
      case (in_req.req_type) inside
        REQ_TICK: begin
          free_time_r <= free_time_r + TIME_W'(1);
          ptr_r       <= '0;
          state_r     <= ST_SWEEP;
        end
        REQ_SET: begin
          if (idx_ok) count_r[sel] <= load_val;
        end
        REQ_START: begin
          if (idx_ok) active_r[sel] <= 1'b1;
        end
        REQ_STOP: begin
          if (idx_ok) active_r[sel] <= 1'b0;
        end
        REQ_INIT: begin
          if (idx_ok) begin
            count_r[sel]   <= load_val;
            expired_r[sel] <= 1'b0;
            active_r[sel]  <= 1'b1;
          end
        end
        REQ_CLEAR_EXPIRED: begin
          if (idx_ok) expired_r[sel] <= 1'b0;
        end
        default: begin
        end
      endcase
    end else if (state_r == ST_SWEEP) begin
      if (active_r[ptr_r]) begin
        count_r[ptr_r] <= dec_val;
        // reaching zero is a one-shot expiry; a zero count wraps and stays active
        if (dec_val == '0) begin
          expired_r[ptr_r] <= 1'b1;
          active_r[ptr_r]  <= 1'b0;
        end
      end
      if (ptr_last) state_r <= ST_IDLE;
      else ptr_r <= ptr_r + IDX_W'(1);
    end
  end

  // output register, loaded on accept; ready gating keeps it from overwriting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      flag_r   <= flag_nxt;
      time_r   <= time_nxt;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = status_r;
  assign out_rsp.answer_flag = flag_r;
  assign out_rsp.time_value  = time_r;

endmodule

// ----- sv/stb_checker.sv -----
// ----------------------------------------------------------------------------
// stb_checker
// Port-level checks on the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
`include "software_timer_bank_top_macros.svh"

module stb_checker import stb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [REQ_W-1:0]  in_req_type,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_status,
  input logic              out_answer_flag,
  input logic [TIME_W-1:0] out_time_value
);

  // every accepted request shows its response the next cycle
  `STB_ASSERT_NEXT(a_rsp_follows, in_valid && in_ready, out_valid, "response missing after request")

  // a tick starts a sweep, so the block cannot take the next request at once
  `STB_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && in_req_type == REQ_TICK, !in_ready,
    "ready high right after tick")

  // ready never lets a new request overwrite a waiting response
  `STB_ASSERT_SAME(a_no_overwrite, in_ready, !out_valid || out_ready,
    "ready while response stalled")

  // unknown request codes report an error
  `STB_ASSERT_NEXT(a_bad_code, in_valid && in_ready && in_req_type > REQ_READ_TIME,
    out_status == STATUS_NO_TIMER && !out_answer_flag && out_time_value == '0,
    "unknown request not rejected")

  // a stalled response holds
  `STB_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_answer_flag) && $stable(out_time_value),
    "stalled response changed")

endmodule

bind software_timer_bank_top stb_checker u_stb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .in_req_type     (in_req.req_type),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_status      (out_rsp.status),
  .out_answer_flag (out_rsp.answer_flag),
  .out_time_value  (out_rsp.time_value)
);
